/* sv/fmp4_pkg.sv */
// Package: constants and types shared by the first-sample byte-cap parser.
`timescale 1ns / 1ps
package fmp4_pkg;
  localparam int unsigned PosW = 33;
  localparam int unsigned CapW = 34;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
  localparam logic [31:0] FourccMoof = 32'h6D6F6F66;
  localparam logic [31:0] FourccTraf = 32'h74726166;
  localparam logic [31:0] FourccTfhd = 32'h74666864;
  localparam logic [31:0] FourccTrun = 32'h7472756E;

  typedef enum logic [2:0] {
    PH_MOOF_HDR,
    PH_MOOF_WALK,
    PH_TRAF_WALK,
    PH_DONE,
    PH_REJECT
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TFHD,
    KIND_TRUN
  } kind_e;

  // Parser status handed to the result stage.
  typedef struct packed {
    logic            valid;
    logic            ok;
    logic [31:0]     moof_len;
    logic [31:0]     first;
  } sum_t;
endpackage

/* sv/fmp4_parse.sv */
// Byte-walking parser: box walk, field capture and result decision per byte.
`timescale 1ns / 1ps
module fmp4_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_take_i,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  input  logic           sum_ready_i,
  output fmp4_pkg::sum_t sum_o
);
  import fmp4_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [63:0]     hs_q, hs_d;
  logic [31:0]     moof_q, moof_d;
  phase_e          ph_q, ph_d;
  logic [PosW-1:0] mch_q, mch_d, tend_q, tend_d, tch_q, tch_d;
  logic            traf_q, traf_d;
  kind_e           kind_q, kind_d;
  logic [PosW-1:0] pst_q, pst_d;
  logic [PosW-1:0] doff_q, doff_d, roff_q, roff_d;
  logic            darm_q, darm_d, rarm_q, rarm_d;
  logic [31:0]     dsz_q, dsz_d, rsz_q, rsz_d;
  sum_t            sum_q, sum_d;

  // Wide intermediates for offset math (one bit above position width).
  logic [PosW:0]   p_w, sz_w, len_w;
  logic [23:0]     flags;
  logic [31:0]     sz, ty, last4;

  always_comb begin
    pos_d = pos_q; hs_d = hs_q; moof_d = moof_q; ph_d = ph_q;
    mch_d = mch_q; tend_d = tend_q; tch_d = tch_q; traf_d = traf_q;
    kind_d = kind_q; pst_d = pst_q; doff_d = doff_q; roff_d = roff_q;
    darm_d = darm_q; rarm_d = rarm_q; dsz_d = dsz_q; rsz_d = rsz_q;
    sum_d = sum_q;
    // a waiting result stays until the output stage takes it
    if (sum_ready_i) sum_d.valid = 1'b0;
    p_w = '0; sz_w = '0; len_w = '0;
    flags = '0; sz = '0; ty = '0; last4 = '0;
    if (in_take_i) begin
      hs_d = {hs_q[55:0], data_byte_i};
      if (pos_q != PosMax) pos_d = pos_q + 1'b1;
      // field captures
      if (darm_q && {1'b0, pos_q} == {1'b0, doff_q} + 34'd3) begin
        dsz_d = hs_d[31:0]; darm_d = 1'b0;
      end
      if (rarm_q && {1'b0, pos_q} == {1'b0, roff_q} + 34'd3) begin
        rsz_d = hs_d[31:0]; rarm_d = 1'b0;
      end
      // full-box flag evaluation
      flags = hs_d[55:32];
      last4 = hs_d[31:0];
      if (kind_q != KIND_NONE && {1'b0, pos_q} == {1'b0, pst_q} + 34'd15) begin
        p_w = {1'b0, pst_q} + 34'd16;
        if (kind_q == KIND_TFHD) begin
          if (flags[0]) p_w = p_w + 34'd8;
          if (flags[1]) p_w = p_w + 34'd4;
          if (flags[3]) p_w = p_w + 34'd4;
          if (flags[4] && p_w + 34'd4 <= {1'b0, tend_q}) begin
            doff_d = p_w[PosW-1:0]; darm_d = 1'b1;
          end
        end else begin
          if (flags[0]) p_w = p_w + 34'd4;
          if (flags[2]) p_w = p_w + 34'd4;
          if (last4 != 32'd0) begin
            if (flags[8] && p_w + 34'd4 <= {1'b0, tend_q}) p_w = p_w + 34'd4;
            if (flags[9] && p_w + 34'd4 <= {1'b0, tend_q}) begin
              roff_d = p_w[PosW-1:0]; rarm_d = 1'b1;
            end
          end
        end
        kind_d = KIND_NONE;
      end
      // box walk
      sz = hs_d[63:32];
      ty = hs_d[31:0];
      unique case (ph_q)
        PH_MOOF_HDR: begin
          if (pos_q == 33'd7) begin
            moof_d = sz;
            if (sz < 32'd8 || ty != FourccMoof) ph_d = PH_REJECT;
            else begin
              mch_d = 33'd8;
              ph_d = (sz < 32'd16) ? PH_DONE : PH_MOOF_WALK;
            end
          end
        end
        PH_MOOF_WALK: begin
          if ({1'b0, pos_q} == {1'b0, mch_q} + 34'd7) begin
            sz_w = {1'b0, mch_q} + {2'b0, sz};
            if (sz < 32'd8 || sz_w > {2'b0, moof_q}) ph_d = PH_DONE;
            else if (ty == FourccTraf) begin
              traf_d = 1'b1;
              tend_d = sz_w[PosW-1:0];
              tch_d = mch_q + 33'd8;
              ph_d = ({1'b0, mch_q} + 34'd16 > sz_w) ? PH_DONE : PH_TRAF_WALK;
            end else begin
              mch_d = sz_w[PosW-1:0];
              if (sz_w + 34'd8 > {2'b0, moof_q}) ph_d = PH_DONE;
            end
          end
        end
        PH_TRAF_WALK: begin
          if ({1'b0, pos_q} == {1'b0, tch_q} + 34'd7) begin
            sz_w = {1'b0, tch_q} + {2'b0, sz};
            if (sz < 32'd8 || sz_w > {1'b0, tend_q}) ph_d = PH_DONE;
            else begin
              if ((ty == FourccTfhd || ty == FourccTrun) &&
                  {1'b0, tch_q} + 34'd16 <= {1'b0, tend_q}) begin
                kind_d = (ty == FourccTfhd) ? KIND_TFHD : KIND_TRUN;
                pst_d = tch_q;
              end
              tch_d = sz_w[PosW-1:0];
              if (sz_w + 34'd8 > {1'b0, tend_q}) ph_d = PH_DONE;
            end
          end
        end
        default: ;
      endcase
      // end of buffer: decide and restart
      if (last_byte_i) begin
        len_w = {1'b0, pos_q} + 34'd1;
        sum_d.valid = 1'b1;
        sum_d.moof_len = moof_d;
        sum_d.first = (rsz_d != 32'd0) ? rsz_d : dsz_d;
        sum_d.ok = len_w >= 34'd8 && ph_d != PH_REJECT && ph_d != PH_MOOF_HDR &&
                   len_w >= {2'b0, moof_d} && traf_d;
        pos_d = '0; hs_d = '0; moof_d = '0; ph_d = PH_MOOF_HDR;
        mch_d = 33'd8; tend_d = '0; tch_d = '0; traf_d = 1'b0;
        kind_d = KIND_NONE; pst_d = '0; doff_d = '0; roff_d = '0;
        darm_d = 1'b0; rarm_d = 1'b0; dsz_d = '0; rsz_d = '0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; hs_q <= '0; moof_q <= '0; ph_q <= PH_MOOF_HDR;
      mch_q <= 33'd8; tend_q <= '0; tch_q <= '0; traf_q <= 1'b0;
      kind_q <= KIND_NONE; pst_q <= '0; doff_q <= '0; roff_q <= '0;
      darm_q <= 1'b0; rarm_q <= 1'b0; dsz_q <= '0; rsz_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d; hs_q <= hs_d; moof_q <= moof_d; ph_q <= ph_d;
      mch_q <= mch_d; tend_q <= tend_d; tch_q <= tch_d; traf_q <= traf_d;
      kind_q <= kind_d; pst_q <= pst_d; doff_q <= doff_d; roff_q <= roff_d;
      darm_q <= darm_d; rarm_q <= rarm_d; dsz_q <= dsz_d; rsz_q <= rsz_d;
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;
endmodule

/* sv/fmp4_out.sv */
// Result stage: final add and output register with stall handling.
`timescale 1ns / 1ps
module fmp4_out (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fmp4_pkg::sum_t            sum_i,
  input  logic                      out_stall_i,
  output logic                      sum_ready_o,
  output logic                      out_valid_o,
  output logic [fmp4_pkg::CapW-1:0] byte_cap_o,
  output logic                      busy_o
);
  import fmp4_pkg::*;

  logic            vld_q;
  logic [CapW-1:0] cap_q, cap_d;

  // moof + 8 + first size, or zero
  always_comb begin
    cap_d = '0;
    if (sum_i.ok && sum_i.first != 32'd0)
      cap_d = {2'b0, sum_i.moof_len} + 34'd8 + {2'b0, sum_i.first};
  end

  // output register is free or drains this cycle
  assign sum_ready_o = !vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (sum_i.valid && sum_ready_o) begin
      vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_i.valid && sum_ready_o) cap_q <= cap_d;
  end

  assign out_valid_o = vld_q;
  assign byte_cap_o  = cap_q;
  // hold input while a finished result waits behind a full output register
  assign busy_o = vld_q && sum_i.valid;
endmodule

/* sv/fmp4_first_sample_byte_cap_top.sv */
// Top level of the fragmented-MP4 first-sample byte-cap parser.
//   channel | direction | handshake          | payload
//   in      | input     | in_valid_i/in_stall_o   | data_byte_i, last_byte_i
//   out     | output    | out_valid_o/out_stall_i | byte_cap_o
// One byte per cycle unless stalled; the byte walk is a single registered pass.
// A result is registered in the parse stage, then in the output register.
// Reset clears all parse state; after each last byte the parser restarts.
// Input stalls while a finished result waits in the parse stage behind a full
// output register; in_stall_o comes from registers only.
`timescale 1ns / 1ps
module fmp4_first_sample_byte_cap_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [fmp4_pkg::CapW-1:0] byte_cap_o
);
  import fmp4_pkg::*;

  sum_t sum;
  logic busy, sum_ready;

  // Stall input while the pending result cannot move on.
  assign in_stall_o = busy;

  fmp4_parse u_parse (
    .clk_i, .rst_ni,
    .in_take_i   (in_valid_i && !in_stall_o),
    .data_byte_i, .last_byte_i,
    .sum_ready_i (sum_ready),
    .sum_o       (sum)
  );

  fmp4_out u_out (
    .clk_i, .rst_ni,
    .sum_i       (sum),
    .out_stall_i,
    .sum_ready_o (sum_ready),
    .out_valid_o,
    .byte_cap_o,
    .busy_o      (busy)
  );
endmodule
